>>> hdl/dbsr_pkg.sv
// Package for the distance-based slot replacement block.
// Sizes, state codes, shared types and the slot search functions.
// No dependencies.
`default_nettype none
package dbsr_pkg;

  localparam int MAX_SLOTS      = 8;
  localparam int MAX_SECTIONS   = 64;
  localparam int PROMPT_ID_BITS = 8;

  localparam int SLOT_W     = $clog2(MAX_SLOTS);
  localparam int CAP_W      = $clog2(MAX_SLOTS + 1);
  localparam int ADDR_W     = $clog2(MAX_SECTIONS);
  localparam int COUNT_W    = $clog2(MAX_SECTIONS + 1);
  localparam int RSV_W      = 3;
  localparam int RSV_CMP_W  = (CAP_W > RSV_W) ? CAP_W : RSV_W;
  localparam int SEC_W      = 6;
  localparam int SLOT_OUT_W = 4;

  localparam logic [SLOT_OUT_W-1:0] SLOT_NONE = '1;

  typedef enum logic {
    OP_LOAD     = 1'b0,
    OP_RESIDENT = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CHK,
    ST_PROT,
    ST_SCAN,
    ST_PICK,
    ST_DONE
  } state_t;

  typedef logic [MAX_SLOTS-1:0][PROMPT_ID_BITS-1:0] slot_arr_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] idx;
  } find_t;

  // Control from the sequencer to the victim unit
  typedef struct packed {
    logic               clr;
    logic               upd;
    logic [SLOT_W-1:0]  idx;
    logic [COUNT_W-1:0] span;
  } scan_t;

  // First slot below capacity that holds the prompt; empty prompt never hits
  function automatic find_t find_slot(slot_arr_t s, logic [PROMPT_ID_BITS-1:0] p,
                                      logic [CAP_W-1:0] cap);
    find_t r;
    r.hit = 1'b0;
    r.idx = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (p != '0 && CAP_W'(i) < cap && s[i] == p) begin
        r.hit = 1'b1;
        r.idx = SLOT_W'(i);
      end
    end
    return r;
  endfunction

  // First empty slot below capacity
  function automatic find_t first_free(slot_arr_t s, logic [CAP_W-1:0] cap);
    find_t r;
    r.hit = 1'b0;
    r.idx = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (CAP_W'(i) < cap && s[i] == '0) begin
        r.hit = 1'b1;
        r.idx = SLOT_W'(i);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/dbsr_ifs.sv
// Valid/ready channel interfaces for the slot replacement block.
// Depends on dbsr_pkg for field widths.
`default_nettype none
interface dbsr_in_if;
  logic                               valid;
  logic                               ready;
  logic                               op;
  logic [dbsr_pkg::SEC_W-1:0]         section;
  logic [dbsr_pkg::SEC_W-1:0]         current_section;
  logic [dbsr_pkg::PROMPT_ID_BITS-1:0] prompt_id;
  logic                               last;
  modport source (output valid, op, section, current_section, prompt_id, last,
                  input ready);
  modport sink (input valid, op, section, current_section, prompt_id, last,
                output ready);
endinterface

interface dbsr_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [dbsr_pkg::SLOT_OUT_W-1:0] slot;
  logic                                  changed;
  logic                                  all_resident;
  modport source (output valid, slot, changed, all_resident, input ready);
  modport sink (input valid, slot, changed, all_resident, output ready);
endinterface
`default_nettype wire

>>> hdl/dbsr_sec_ram.sv
// Section-to-prompt table: one write port, one read port, registered read.
// Depends on dbsr_pkg.
`default_nettype none
module dbsr_sec_ram (
  input  wire logic                               clk,
  input  wire logic                               we,
  input  wire logic [dbsr_pkg::ADDR_W-1:0]         waddr,
  input  wire logic [dbsr_pkg::PROMPT_ID_BITS-1:0] wdata,
  input  wire logic [dbsr_pkg::ADDR_W-1:0]         raddr,
  output logic      [dbsr_pkg::PROMPT_ID_BITS-1:0] rdata
);
  import dbsr_pkg::*;

  logic [PROMPT_ID_BITS-1:0] mem [MAX_SECTIONS];

  // Write, and read with a registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hdl/dbsr_victim.sv
// Victim unit: nearest-user distance per slot, built up over a section scan,
// and the eviction choice from it. Depends on dbsr_pkg.
`default_nettype none
module dbsr_victim (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire dbsr_pkg::scan_t           scan,
  input  wire logic                      prot_valid,
  input  wire logic [dbsr_pkg::SLOT_W-1:0] prot_idx,
  input  wire logic [dbsr_pkg::CAP_W-1:0]  cap,
  output logic      [dbsr_pkg::SLOT_W-1:0] victim
);
  import dbsr_pkg::*;

  logic [MAX_SLOTS-1:0]              used;
  logic [MAX_SLOTS-1:0][COUNT_W-1:0] nearest;

  // Keep the smallest distance seen per slot
  always_ff @(posedge clk) begin
    if (rst || scan.clr) begin
      used <= '0;
    end else if (scan.upd && (!used[scan.idx] || scan.span < nearest[scan.idx])) begin
      used[scan.idx]    <= 1'b1;
      nearest[scan.idx] <= scan.span;
    end
  end

  // Pick among unprotected slots below capacity: first unused, else furthest nearest user, else slot 0
  always_comb begin
    logic              free_hit;
    logic [SLOT_W-1:0] free_idx;
    logic              worst_hit;
    logic [SLOT_W-1:0] worst_idx;
    logic [COUNT_W-1:0] worst_dist;
    free_hit   = 1'b0;
    free_idx   = '0;
    worst_hit  = 1'b0;
    worst_idx  = '0;
    worst_dist = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (CAP_W'(i) < cap && !(prot_valid && prot_idx == SLOT_W'(i))) begin
        if (!used[i]) begin
          if (!free_hit) begin
            free_hit = 1'b1;
            free_idx = SLOT_W'(i);
          end
        end else if (!worst_hit || nearest[i] > worst_dist) begin
          worst_hit  = 1'b1;
          worst_idx  = SLOT_W'(i);
          worst_dist = nearest[i];
        end
      end
    end
    if (free_hit) begin
      victim = free_idx;
    end else if (worst_hit) begin
      victim = worst_idx;
    end else begin
      victim = '0;
    end
  end
endmodule
`default_nettype wire

>>> hdl/distance_based_slot_replacement.sv
// Top level of the distance-based slot replacement block: sequencer, slot
// registers, output register. Depends on dbsr_pkg, dbsr_ifs, dbsr_sec_ram,
// dbsr_victim.
//
//  channel  | role   | payload
//  in_ch    | sink   | op, section, current_section, prompt_id, last
//  out_ch   | source | slot, changed, all_resident
//  cfg      | write  | cfg_wdata -> reserved when cfg_we
//
// A load passes ST_LOAD, and a make-resident hit or a free-slot fill passes
// ST_CHK, before ST_DONE registers the result and the block returns to ST_IDLE
// for the next input. An eviction adds ST_PROT, a scan of the section table
// through its single read port in ST_SCAN, and ST_PICK.
// One item is worked at a time; a new item is taken while a result waits.
// Synchronous reset clears slots, counters and flags; the table needs no clear.
`default_nettype none
module distance_based_slot_replacement (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [dbsr_pkg::RSV_W-1:0]     cfg_wdata,
  dbsr_in_if.sink                            in_ch,
  dbsr_out_if.source                         out_ch
);
  import dbsr_pkg::*;

  state_t state, state_next;

  logic [RSV_W-1:0]          reserved;
  slot_arr_t                 slots;
  logic [COUNT_W-1:0]        count;
  logic                      loaded;
  logic [CAP_W-1:0]          fill;
  logic                      fr;
  logic                      it_op;
  logic [SEC_W-1:0]          it_sec;
  logic [SEC_W-1:0]          it_cur;
  logic [PROMPT_ID_BITS-1:0] it_p;
  logic                      it_last;
  logic [PROMPT_ID_BITS-1:0] q_r;
  logic                      prot_valid;
  logic [SLOT_W-1:0]         prot_idx;
  logic [COUNT_W-1:0]        cnt;
  logic                      dv;
  logic [ADDR_W-1:0]         sd;
  logic [SLOT_OUT_W-1:0]     res_slot;
  logic                      res_changed;

  logic [CAP_W-1:0]          cap;
  logic [RSV_CMP_W-1:0]      rsv_ext;
  logic [ADDR_W-1:0]         raddr;
  logic [PROMPT_ID_BITS-1:0] ram_q;
  logic                      ram_we;
  logic [SLOT_W-1:0]         victim;
  scan_t                     scan;
  find_t                     q_find;
  find_t                     free_find;
  find_t                     scan_find;
  logic [COUNT_W-1:0]        sd_ext;
  logic [COUNT_W-1:0]        cur_ext;

  // Load path signals
  slot_arr_t                 ld_slots;
  logic [COUNT_W-1:0]        ld_count;
  logic [CAP_W-1:0]          ld_fill;
  logic                      ld_fr;
  logic                      ld_seen;
  find_t                     ld_find;

  // Capacity after reserved slots
  always_comb begin
    rsv_ext = RSV_CMP_W'(reserved);
    if (rsv_ext > RSV_CMP_W'(MAX_SLOTS - 1)) begin
      cap = CAP_W'(1);
    end else begin
      cap = CAP_W'(MAX_SLOTS) - CAP_W'(rsv_ext);
    end
  end

  // Load: start a new song if one is loaded, append, seed the slots
  always_comb begin
    ld_slots = loaded ? '0 : slots;
    ld_count = loaded ? '0 : count;
    ld_fill  = loaded ? '0 : fill;
    ld_fr    = loaded ? 1'b1 : fr;
    ld_seen  = 1'b0;
    ld_find  = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (CAP_W'(i) < ld_fill && ld_slots[i] == it_p) begin
        ld_seen = 1'b1;
      end
    end
    ram_we = (state == ST_LOAD) && (ld_count < COUNT_W'(MAX_SECTIONS));
    if (ld_count < COUNT_W'(MAX_SECTIONS)) begin
      if (it_p != '0 && !ld_seen) begin
        if (ld_fill < cap) begin
          ld_slots[ld_fill[SLOT_W-1:0]] = it_p;
          ld_fill = ld_fill + CAP_W'(1);
        end else begin
          ld_fr = 1'b0;
        end
      end
      ld_count = ld_count + COUNT_W'(1);
      ld_find  = find_slot(ld_slots, it_p, cap);
    end
  end

  // Lookups on table read data
  assign q_find    = find_slot(slots, ram_q, cap);
  assign free_find = first_free(slots, cap);
  assign scan_find = find_slot(slots, ram_q, cap);
  assign sd_ext    = COUNT_W'(sd);
  assign cur_ext   = COUNT_W'(it_cur);

  // Scan control to the victim unit
  always_comb begin
    scan.clr  = (state == ST_PROT);
    scan.upd  = (state == ST_SCAN) && dv && scan_find.hit;
    scan.idx  = scan_find.idx;
    scan.span = (sd_ext > cur_ext) ? sd_ext - cur_ext : cur_ext - sd_ext;
  end

  // Next state and read address
  always_comb begin
    state_next = state;
    raddr      = cnt[ADDR_W-1:0];
    unique case (state)
      ST_IDLE: begin
        raddr = ADDR_W'(in_ch.section);
        if (in_ch.valid) begin
          state_next = (op_t'(in_ch.op) == OP_LOAD) ? ST_LOAD : ST_CHK;
        end
      end
      ST_LOAD: begin
        state_next = ST_DONE;
      end
      ST_CHK: begin
        raddr = ADDR_W'(it_cur);
        if (!loaded || COUNT_W'(it_sec) >= count || q_find.hit || free_find.hit) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_PROT;
        end
      end
      ST_PROT: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt >= count && !dv) begin
          state_next = ST_PICK;
        end
      end
      ST_PICK: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_ch.valid || out_ch.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_ch.ready = (state == ST_IDLE);

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= '0;
    end else if (cfg_we) begin
      reserved <= cfg_wdata;
    end
  end

  // Slot registers and song state
  always_ff @(posedge clk) begin
    if (rst) begin
      slots  <= '0;
      count  <= '0;
      loaded <= 1'b0;
      fill   <= '0;
      fr     <= 1'b1;
    end else begin
      unique case (state)
        ST_LOAD: begin
          slots  <= ld_slots;
          count  <= ld_count;
          fill   <= ld_fill;
          fr     <= ld_fr;
          loaded <= it_last;
        end
        ST_CHK: begin
          if (loaded && COUNT_W'(it_sec) < count && !q_find.hit && free_find.hit) begin
            slots[free_find.idx] <= ram_q;
          end
        end
        ST_PICK: begin
          slots[victim] <= q_r;
        end
        default: begin
        end
      endcase
    end
  end

  // Item capture, scan counter, result
  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          it_op   <= in_ch.op;
          it_sec  <= in_ch.section;
          it_cur  <= in_ch.current_section;
          it_p    <= in_ch.prompt_id;
          it_last <= in_ch.last;
        end
        ST_LOAD: begin
          res_slot    <= ld_find.hit ? SLOT_OUT_W'(ld_find.idx) : SLOT_NONE;
          res_changed <= 1'b0;
        end
        ST_CHK: begin
          q_r         <= ram_q;
          res_changed <= 1'b0;
          res_slot    <= SLOT_NONE;
          if (loaded && COUNT_W'(it_sec) < count) begin
            if (q_find.hit) begin
              res_slot <= SLOT_OUT_W'(q_find.idx);
            end else if (free_find.hit) begin
              res_slot    <= SLOT_OUT_W'(free_find.idx);
              res_changed <= 1'b1;
            end
          end
        end
        ST_PROT: begin
          prot_valid <= (cur_ext < count) && q_find.hit;
          prot_idx   <= q_find.idx;
          cnt        <= '0;
          dv         <= 1'b0;
        end
        ST_SCAN: begin
          if (cnt < count) begin
            cnt <= cnt + COUNT_W'(1);
            sd  <= cnt[ADDR_W-1:0];
            dv  <= 1'b1;
          end else begin
            dv <= 1'b0;
          end
        end
        ST_PICK: begin
          res_slot    <= SLOT_OUT_W'(victim);
          res_changed <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (state == ST_DONE && (!out_ch.valid || out_ch.ready)) begin
      out_ch.valid        <= 1'b1;
      out_ch.slot         <= res_slot;
      out_ch.changed      <= res_changed;
      out_ch.all_resident <= fr;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  dbsr_sec_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ld_count[ADDR_W-1:0] - ADDR_W'(1)),
    .wdata (it_p),
    .raddr (raddr),
    .rdata (ram_q)
  );

  dbsr_victim u_victim (
    .clk        (clk),
    .rst        (rst),
    .scan       (scan),
    .prot_valid (prot_valid),
    .prot_idx   (prot_idx),
    .cap        (cap),
    .victim     (victim)
  );

`ifndef ASSERT_OFF
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while an item is in work");
  a_changed_has_slot: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.changed |-> out_ch.slot != SLOT_NONE)
    else $error("slot written without a slot index");
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> cnt <= count)
    else $error("scan ran past section count");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CAP_W'(MAX_SLOTS))
    else $error("seed fill beyond slot count");
  a_load_only_item: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD |-> it_op == OP_LOAD)
    else $error("load work on a make-resident item");
`endif
endmodule
`default_nettype wire

>>> dv/dbsr_tb_ifs_note.sv
`timescale 1ns / 1ps
// Testbench-side helper types for the slot replacement testbench.
// Depends on dbsr_pkg; the channel interfaces come from hdl/dbsr_ifs.sv.
package dbsr_tb_pkg;
  import dbsr_pkg::*;

  typedef struct packed {
    op_t                       op;
    logic [SEC_W-1:0]          section;
    logic [SEC_W-1:0]          current_section;
    logic [PROMPT_ID_BITS-1:0] prompt_id;
    logic                      last;
  } req_t;

  typedef struct packed {
    logic signed [SLOT_OUT_W-1:0] slot;
    logic                         changed;
    logic                         all_resident;
  } rsp_t;
endpackage

>>> dv/tb.sv
`timescale 1ns / 1ps
// Testbench for distance_based_slot_replacement: random song loads and
// make-resident requests, checked against an in-bench slot predictor.
// Depends on dbsr_pkg, dbsr_tb_pkg, dbsr_ifs and the RTL.
module tb;
  import dbsr_pkg::*;
  import dbsr_tb_pkg::*;

  localparam int SETTLE = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [RSV_W-1:0] cfg_wdata = '0;

  dbsr_in_if in_ch ();
  dbsr_out_if out_ch ();

  distance_based_slot_replacement uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #6 clk = ~clk;

  // Predictor state
  logic [PROMPT_ID_BITS-1:0] slots_m [MAX_SLOTS];
  logic [PROMPT_ID_BITS-1:0] sec_m [MAX_SECTIONS];
  int unsigned sec_cnt_m, seed_m, rsv_m;
  bit song_m, full_m;

  req_t pending_q[$];
  rsp_t expected_q[$];
  int errors = 0;
  bit stim_done = 0;
  bit in_took = 0;

  function automatic int cap_now();
    return MAX_SLOTS - ((rsv_m > MAX_SLOTS - 1) ? MAX_SLOTS - 1 : rsv_m);
  endfunction

  function automatic int slot_holding(logic [PROMPT_ID_BITS-1:0] p, int cap);
    if (p == '0) return -1;
    for (int i = 0; i < cap; i++) if (slots_m[i] == p) return i;
    return -1;
  endfunction

  function automatic int section_slot(int s, int cap);
    if (s < 0 || s >= int'(sec_cnt_m)) return -1;
    return slot_holding(sec_m[s], cap);
  endfunction

  // Choose a slot to overwrite: free, unused, furthest nearest user, else 0
  function automatic int choose_victim(int cur, int cap);
    int guard, far, far_d, nearest, d;
    far = -1;
    far_d = -1;
    for (int i = 0; i < cap; i++) if (slots_m[i] == '0) return i;
    guard = section_slot(cur, cap);
    for (int i = 0; i < cap; i++) begin
      if (i == guard) continue;
      nearest = -1;
      for (int s = 0; s < int'(sec_cnt_m); s++) begin
        if (section_slot(s, cap) != i) continue;
        d = (s > cur) ? s - cur : cur - s;
        if (nearest < 0 || d < nearest) nearest = d;
      end
      if (nearest < 0) return i;
      if (nearest > far_d) begin
        far_d = nearest;
        far = i;
      end
    end
    return (far >= 0) ? far : 0;
  endfunction

  function automatic rsp_t predict_slot(req_t r);
    rsp_t o;
    int cap, sl;
    bit seen;
    cap = cap_now();
    sl = -1;
    o.changed = 1'b0;
    if (r.op == OP_LOAD) begin
      if (song_m) begin
        foreach (slots_m[i]) slots_m[i] = '0;
        sec_cnt_m = 0;
        seed_m = 0;
        full_m = 1;
        song_m = 0;
      end
      if (sec_cnt_m < MAX_SECTIONS) begin
        sec_m[sec_cnt_m] = r.prompt_id;
        sec_cnt_m++;
        if (r.prompt_id != '0) begin
          seen = 0;
          for (int i = 0; i < int'(seed_m) && i < MAX_SLOTS; i++)
            if (slots_m[i] == r.prompt_id) seen = 1;
          if (!seen) begin
            if (seed_m < cap) begin
              slots_m[seed_m] = r.prompt_id;
              seed_m++;
            end else full_m = 0;
          end
        end
        sl = slot_holding(r.prompt_id, cap);
      end
      if (r.last) song_m = 1;
    end else if (song_m && r.section < sec_cnt_m) begin
      sl = slot_holding(sec_m[r.section], cap);
      if (sl < 0) begin
        sl = choose_victim(int'(r.current_section), cap);
        slots_m[sl] = sec_m[r.section];
        o.changed = 1'b1;
      end
    end
    o.slot = SLOT_OUT_W'(sl);
    o.all_resident = full_m;
    return o;
  endfunction

  // Driver: bursts with random gaps, inputs change at falling edge
  int gap_left = 0, burst_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_took) begin
      // hold until transfer
    end else begin
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      end
      if (gap_left > 0 || pending_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid <= 1'b1;
        {in_ch.op, in_ch.section, in_ch.current_section, in_ch.prompt_id, in_ch.last}
          <= pending_q.pop_front();
        if (burst_left > 0) burst_left--;
      end
    end
  end

  // Receiver stall pattern
  int stall_ph = 0;
  always @(negedge clk) begin
    stall_ph <= stall_ph + 1;
    if (rst) out_ch.ready <= 1'b0;
    else if (stall_ph[8]) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  // Monitor: predict on input transfer, compare on output transfer
  always @(posedge clk) begin
    rsp_t got, exp_r;
    in_took = !rst && in_ch.valid && in_ch.ready;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        exp_r = predict_slot({op_t'(in_ch.op), in_ch.section,
          in_ch.current_section, in_ch.prompt_id, in_ch.last});
        expected_q = {expected_q, exp_r};
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.slot, out_ch.changed, out_ch.all_resident};
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", got);
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p got %p", exp_r, got);
          end
        end
      end
    end
  end

  task automatic add_item(op_t op, int sec, int cur, int p, bit lst);
    req_t r;
    r.op = op;
    r.section = SEC_W'(sec);
    r.current_section = SEC_W'(cur);
    r.prompt_id = PROMPT_ID_BITS'(p);
    r.last = lst;
    pending_q = {pending_q, r};
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !in_ch.valid && expected_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_reserved(int v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= RSV_W'(v);
    @(negedge clk);
    cfg_we <= 1'b0;
    rsv_m = v;
  endtask

  // Random song: loads then make-resident requests mostly within the song
  task automatic add_song(int n, int alphabet, int reqs);
    for (int i = 0; i < n; i++)
      add_item(OP_LOAD, $urandom, $urandom,
               ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, alphabet),
               i == n - 1);
    for (int i = 0; i < reqs; i++)
      add_item(OP_RESIDENT,
               ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1),
               ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1),
               $urandom, $urandom);
  endtask

  initial begin
    int total;
    foreach (slots_m[i]) slots_m[i] = '0;
    sec_cnt_m = 0; seed_m = 0; rsv_m = 0; song_m = 0; full_m = 1;
    in_ch.valid = 1'b0; in_ch.op = 1'b0; in_ch.section = '0;
    in_ch.current_section = '0; in_ch.prompt_id = '0; in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: no song, extremes, empty prompts, overflow, out of range
    add_item(OP_RESIDENT, 0, 0, 0, 0);
    add_item(OP_LOAD, 63, 63, 255, 0);
    add_item(OP_LOAD, 0, 0, 0, 0);
    add_item(OP_LOAD, 0, 0, 255, 0);
    for (int i = 1; i <= 9; i++) add_item(OP_LOAD, 0, 0, i, i == 9);
    add_item(OP_RESIDENT, 1, 63, 0, 1);
    add_item(OP_RESIDENT, 40, 0, 0, 0);
    add_item(OP_RESIDENT, 11, 1, 0, 0);
    add_item(OP_RESIDENT, 12, 63, 0, 0);
    add_item(OP_RESIDENT, 0, 3, 0, 0);
    drain();

    // Full section table, then drop past 64 with last ending the song
    set_reserved(7);
    for (int i = 0; i < 66; i++) add_item(OP_LOAD, 0, 0, (i % 5) + 1, i == 65);
    add_item(OP_RESIDENT, 63, 0, 0, 0);
    add_item(OP_RESIDENT, 2, 0, 0, 0);
    drain();

    total = 0;
    for (int ph = 0; ph < 6; ph++) begin
      set_reserved((ph == 0) ? 0 : (ph == 1) ? 7 : $urandom_range(0, 7));
      while (total < (ph + 1) * 170) begin
        int n, reqs;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 16);
        reqs = $urandom_range(2, 30);
        add_song(n, $urandom_range(1, 14), reqs);
        total += n + reqs;
        if ($urandom_range(0, 9) == 0) add_item(op_t'($urandom_range(0, 1)),
          $urandom, $urandom, $urandom, $urandom);
      end
      drain();
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (errors == 0) $display("[distance_based_slot_replacement] OK");
    else $display("[distance_based_slot_replacement] ERROR");
    $finish;
  end

  initial begin
    #30ms;
    $display("[distance_based_slot_replacement] ERROR");
    $finish;
  end
endmodule
